FILE: sv/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

	// Field widths of the pixel items.
	localparam int unsigned HUE_W = 16;
	localparam int unsigned SV_W  = 9;
	localparam int unsigned RGB_W = 8;

	// Hue units in one 60-degree sector, and the value that means 360 degrees.
	localparam int unsigned SECTOR_UNITS = 7680;
	localparam int unsigned HUE_FULL     = 46080;
	localparam int unsigned ONE_Q8       = 256;
	localparam int unsigned SECTOR_COUNT = 6;

	// Width of a sector weight k in 0..SECTOR_UNITS.
	localparam int unsigned K_W = 13;

	// 256 * 7680, the weight of full brightness before the saturation term.
	localparam int unsigned FULL_SCALE = ONE_Q8 * SECTOR_UNITS;
	localparam int unsigned T_W        = 21;
	localparam int unsigned P_W        = 22;

	// Brightness times 255.
	localparam int unsigned VS_W = 17;

	// Product of brightness*255 and the weight, and the part kept after the
	// division by 2^25 (the power-of-two share of 256*256*7680).
	localparam int unsigned NUM_W   = VS_W + T_W;
	localparam int unsigned NUM_SHR = 25;
	localparam int unsigned X_W     = NUM_W - NUM_SHR;

	// Division of X by 15 as a multiply by ceil(2^19 / 15) and a shift;
	// exact for every X below 2^13.
	localparam int unsigned RECIP15     = 34953;
	localparam int unsigned RECIP_W     = 16;
	localparam int unsigned RECIP_SHR   = 19;
	localparam int unsigned Q_W         = X_W + RECIP_W;
	localparam int unsigned CHAN_MAX    = 255;

	// Decoded pixel: clamped saturation, brightness, one weight per channel and a black flag.
	typedef struct packed {
		logic [SV_W-1:0] sat;
		logic [SV_W-1:0] bright;
		logic [K_W-1:0]  k_red;
		logic [K_W-1:0]  k_green;
		logic [K_W-1:0]  k_blue;
		logic            black;
	} dec_t;

endpackage

FILE: sv/hsv2rgb_in_if.sv
interface hsv2rgb_in_if;
	logic                             valid;
	logic                             ready;
	logic [hsv2rgb_pkg::HUE_W-1:0]    hue;
	logic [hsv2rgb_pkg::SV_W-1:0]     saturation;
	logic [hsv2rgb_pkg::SV_W-1:0]     brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

FILE: sv/hsv2rgb_out_if.sv
interface hsv2rgb_out_if;
	logic                             valid;
	logic                             ready;
	logic [hsv2rgb_pkg::RGB_W-1:0]    red;
	logic [hsv2rgb_pkg::RGB_W-1:0]    green;
	logic [hsv2rgb_pkg::RGB_W-1:0]    blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

FILE: sv/hsv_to_rgb_converter.sv
// Channel   Dir   Handshake      Payload
// pix_in    in    valid/ready    hue[15:0], saturation[8:0], brightness[8:0]
// pix_out   out   valid/ready    red[7:0], green[7:0], blue[7:0]
//
// One pixel enters per cycle while the output is not stalled.
// Stage 1 decodes the sector and picks a weight per channel, stage 2 forms
// the saturation product, stage 3 the brightness product, and stage 4 divides
// by 15 through a reciprocal multiply and drives the output register.
// Reset clears the valid bits only; the data registers are not reset.
// When the output is valid but not taken, every stage holds and pix_in.ready
// drops, so no item is lost or repeated.

module hsv_to_rgb_converter (
	input logic           clk,
	input logic           arst_n,
	hsv2rgb_in_if.sink    pix_in,
	hsv2rgb_out_if.source pix_out
);

	logic              en;
	logic              v_s1;
	logic              v_s2;
	logic              v_s3;
	logic              v_s4;
	hsv2rgb_pkg::dec_t dec_s1;

	// The whole pipeline moves together unless the output holds an item
	// that the sink has not taken yet.
	assign en           = !v_s4 || pix_out.ready;
	assign pix_in.ready = en;
	assign pix_out.valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pix_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: clamp saturation, fold 360 degrees to 0 and find the sector.
	hsv2rgb_decode u_decode (
		.clk        (clk),
		.en         (en),
		.hue        (pix_in.hue),
		.saturation (pix_in.saturation),
		.brightness (pix_in.brightness),
		.dec_s1     (dec_s1)
	);

	// Stages 2 to 4: one arithmetic lane per color channel.
	hsv2rgb_lane u_lane_red (
		.clk     (clk),
		.en      (en),
		.sat     (dec_s1.sat),
		.bright  (dec_s1.bright),
		.k       (dec_s1.k_red),
		.black   (dec_s1.black),
		.chan_s4 (pix_out.red)
	);

	hsv2rgb_lane u_lane_green (
		.clk     (clk),
		.en      (en),
		.sat     (dec_s1.sat),
		.bright  (dec_s1.bright),
		.k       (dec_s1.k_green),
		.black   (dec_s1.black),
		.chan_s4 (pix_out.green)
	);

	hsv2rgb_lane u_lane_blue (
		.clk     (clk),
		.en      (en),
		.sat     (dec_s1.sat),
		.bright  (dec_s1.bright),
		.k       (dec_s1.k_blue),
		.black   (dec_s1.black),
		.chan_s4 (pix_out.blue)
	);

endmodule

FILE: sv/hsv2rgb_decode.sv
module hsv2rgb_decode (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hsv2rgb_pkg::HUE_W-1:0] hue,
	input  logic [hsv2rgb_pkg::SV_W-1:0]  saturation,
	input  logic [hsv2rgb_pkg::SV_W-1:0]  brightness,
	output hsv2rgb_pkg::dec_t             dec_s1
);

	logic [hsv2rgb_pkg::SV_W-1:0]  sat_c;
	logic [hsv2rgb_pkg::HUE_W-1:0] hue_e;
	logic [hsv2rgb_pkg::HUE_W-1:0] base;
	logic [2:0]                    sector;
	logic                          beyond;
	logic [hsv2rgb_pkg::K_W-1:0]   k_a;
	logic [hsv2rgb_pkg::K_W-1:0]   k_b;
	logic [hsv2rgb_pkg::K_W-1:0]   k_c;
	logic [hsv2rgb_pkg::K_W-1:0]   k_full;
	hsv2rgb_pkg::dec_t             dec;

	always_comb begin
		sat_c = (saturation > hsv2rgb_pkg::SV_W'(hsv2rgb_pkg::ONE_Q8))
			? hsv2rgb_pkg::SV_W'(hsv2rgb_pkg::ONE_Q8) : saturation;
		hue_e = (hue == hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_FULL)) ? '0 : hue;

		// Sector search over five fixed thresholds; each compare is independent.
		sector = '0;
		base   = '0;
		for (int i = 1; i < hsv2rgb_pkg::SECTOR_COUNT; i++) begin
			if (hue_e >= hsv2rgb_pkg::HUE_W'(i * hsv2rgb_pkg::SECTOR_UNITS)) begin
				sector = 3'(i);
				base   = hsv2rgb_pkg::HUE_W'(i * hsv2rgb_pkg::SECTOR_UNITS);
			end
		end
		beyond = hue_e >= hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::SECTOR_COUNT
			* hsv2rgb_pkg::SECTOR_UNITS);

		k_full = '0;
		k_a    = hsv2rgb_pkg::K_W'(hsv2rgb_pkg::SECTOR_UNITS);
		k_b    = hsv2rgb_pkg::K_W'(hue_e - base);
		k_c    = hsv2rgb_pkg::K_W'(hsv2rgb_pkg::SECTOR_UNITS) - k_b;

		dec.sat    = sat_c;
		dec.bright = brightness;
		dec.black  = beyond && (sat_c != '0);
		case (sector)
			3'd0: begin
				dec.k_red = k_full; dec.k_green = k_c;    dec.k_blue = k_a;
			end
			3'd1: begin
				dec.k_red = k_b;    dec.k_green = k_full; dec.k_blue = k_a;
			end
			3'd2: begin
				dec.k_red = k_a;    dec.k_green = k_full; dec.k_blue = k_c;
			end
			3'd3: begin
				dec.k_red = k_a;    dec.k_green = k_b;    dec.k_blue = k_full;
			end
			3'd4: begin
				dec.k_red = k_c;    dec.k_green = k_a;    dec.k_blue = k_full;
			end
			default: begin
				dec.k_red = k_full; dec.k_green = k_a;    dec.k_blue = k_b;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= dec;
		end
	end

endmodule

FILE: sv/hsv2rgb_lane.sv
module hsv2rgb_lane (
	input  logic                         clk,
	input  logic                         en,
	input  logic [hsv2rgb_pkg::SV_W-1:0] sat,
	input  logic [hsv2rgb_pkg::SV_W-1:0] bright,
	input  logic [hsv2rgb_pkg::K_W-1:0]  k,
	input  logic                         black,
	output logic [hsv2rgb_pkg::RGB_W-1:0] chan_s4
);

	logic [hsv2rgb_pkg::P_W-1:0]   prod;
	logic [hsv2rgb_pkg::T_W-1:0]   t_s2;
	logic [hsv2rgb_pkg::VS_W-1:0]  vs_s2;
	logic                          black_s2;
	logic [hsv2rgb_pkg::NUM_W-1:0] num;
	logic [hsv2rgb_pkg::X_W-1:0]   x_s3;
	logic                          black_s3;
	logic [hsv2rgb_pkg::Q_W-1:0]   q;
	logic [hsv2rgb_pkg::Q_W-hsv2rgb_pkg::RECIP_SHR-1:0] qv;
	logic [hsv2rgb_pkg::RGB_W-1:0] chan;

	// The weight S*k never exceeds 256*7680, so the difference is never negative.
	assign prod = hsv2rgb_pkg::P_W'(sat) * hsv2rgb_pkg::P_W'(k);
	assign num  = hsv2rgb_pkg::NUM_W'(vs_s2) * hsv2rgb_pkg::NUM_W'(t_s2);
	assign q    = hsv2rgb_pkg::Q_W'(x_s3) * hsv2rgb_pkg::Q_W'(hsv2rgb_pkg::RECIP15);
	assign qv   = q[hsv2rgb_pkg::Q_W-1:hsv2rgb_pkg::RECIP_SHR];

	always_comb begin
		if (black_s3) begin
			chan = '0;
		end else if (qv > (hsv2rgb_pkg::Q_W - hsv2rgb_pkg::RECIP_SHR)'(hsv2rgb_pkg::CHAN_MAX)) begin
			chan = hsv2rgb_pkg::RGB_W'(hsv2rgb_pkg::CHAN_MAX);
		end else begin
			chan = qv[hsv2rgb_pkg::RGB_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2     <= hsv2rgb_pkg::T_W'(hsv2rgb_pkg::P_W'(hsv2rgb_pkg::FULL_SCALE) - prod);
			vs_s2    <= {bright, 8'd0} - hsv2rgb_pkg::VS_W'(bright);
			black_s2 <= black;
			x_s3     <= num[hsv2rgb_pkg::NUM_W-1:hsv2rgb_pkg::NUM_SHR];
			black_s3 <= black_s2;
			chan_s4  <= chan;
		end
	end

endmodule

FILE: sv/hsv2rgb_checker.sv
module hsv2rgb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	// A stalled result keeps its color.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
		else $error("output item changed while stalled");

	// The input is only held off by a stalled output.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off without an output stall");

	// An item accepted into a free-running pipe shows up at the output.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("accepted item did not reach the output");

	// Reset empties the pipe.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.red       (pix_out.red),
	.green     (pix_out.green),
	.blue      (pix_out.blue)
);
